// File: src/scb_pkg.sv
// shared types and constants for the scaled column blit frame store
package scb_pkg;

    // width of signed pixel coordinates inside the block
    localparam int COORD_W = 12;

    // item kinds carried on the input tuser
    localparam logic [1:0] MODE_DRAW  = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // per-cycle request from the sequencer to the store
    typedef struct packed {
        logic                      rd_en;  // read the addressed byte
        logic                      merge;  // write back the merged byte next cycle
        logic                      clr_en; // write zero to the addressed byte
        logic signed [COORD_W-1:0] row0;   // pixel row of bit 0 minus draw base row
    } scb_req_t;

    // draw parameters held for the whole item
    typedef struct packed {
        logic [7:0] bits;      // source column after optional complement
        logic [1:0] scale_log; // square size is two to this power
    } scb_draw_t;

endpackage

// File: src/scb_store.sv
// frame store memory with read-modify-write merge stage
module scb_store #(
    parameter int DEPTH = 504,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  scb_pkg::scb_req_t   req,
    input  logic [AW-1:0]       addr,
    input  scb_pkg::scb_draw_t  draw,
    output logic [7:0]          rd_data,
    output logic                wb_busy
);

    logic [7:0]                          mem [DEPTH];
    logic [7:0]                          rd_q_reg;
    logic                                wb_valid_reg;
    logic [AW-1:0]                       wb_addr_reg;
    logic signed [scb_pkg::COORD_W-1:0]  wb_row0_reg;
    logic [7:0]                          merged;

    // replace the bits whose rows fall inside the scaled column
    always_comb
    begin
        logic signed [scb_pkg::COORD_W-1:0] d;
        logic [scb_pkg::COORD_W-1:0]        span;
        logic [5:0]                         rel;
        logic [2:0]                         src;
        span = scb_pkg::COORD_W'(8) << draw.scale_log;
        for (int k = 0; k < 8; k++)
        begin
            d   = wb_row0_reg + scb_pkg::COORD_W'(k);
            rel = d[5:0] >> draw.scale_log;
            src = rel[2:0];
            if (!d[scb_pkg::COORD_W-1] && ($unsigned(d) < span))
                merged[k] = draw.bits[src];
            else
                merged[k] = rd_q_reg[k];
        end
    end

    // memory write and read ports
    always_ff @(posedge clk)
    begin
        if (req.clr_en)
            mem[addr] <= 8'h00;
        else if (wb_valid_reg)
            mem[wb_addr_reg] <= merged;
        if (req.rd_en)
            rd_q_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
            wb_addr_reg  <= '0;
            wb_row0_reg  <= '0;
        end
        else
        begin
            wb_valid_reg <= req.rd_en && req.merge;
            if (req.rd_en)
            begin
                wb_addr_reg <= addr;
                wb_row0_reg <= req.row0;
            end
        end
    end

    assign rd_data = rd_q_reg;
    assign wb_busy = wb_valid_reg;

    a_no_clear_during_wb: assert property (@(posedge clk) disable iff (!rst_n)
        wb_valid_reg |-> !req.clr_en)
        else $error("clear sweep overlaps a pending write back");

    a_wb_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        (req.rd_en && req.merge) |=> wb_valid_reg && (wb_addr_reg == $past(addr)))
        else $error("merge read not followed by write back at its address");

    a_read_not_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.rd_en && req.clr_en))
        else $error("read and clear requested together");

endmodule

// File: src/scaled_column_blit_framebuffer_unit.sv
// top level: scaled column blit into a monochrome page frame store
// the frame store holds SCREEN_PAGES pages of SCREEN_COLUMNS bytes in one synchronous
// memory; bit k of a byte is pixel row k of its page. after reset, and after every clear
// item, the block sweeps the store to zero one byte per cycle and takes no item meanwhile.
// a draw item passes a setup state, then walks every (column, page) pair the scaled
// square touches: size columns times size or size+1 pages; off-screen pairs are walked
// too. each on-screen pair is a read, a merge of the covered rows and a write back,
// pipelined one pair a cycle through the memory's read and write ports, and the last
// write back lands before the next item is taken. a read item inside the screen passes
// ST_READ and ST_RDATA, one outside skips the memory; each returns its byte through an
// output register, so the next item is accepted while the result waits; a read item
// waits for that register to empty before it issues.
// a mode 3 item is accepted and ignored. reads outside the screen return zero.
module scaled_column_blit_framebuffer_unit #(
    parameter int SCREEN_COLUMNS = 84,
    parameter int SCREEN_PAGES   = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // column_bits[7:0], origin_x[15:8], origin_y[22:16], offset_x[32:23],
    // offset_page[38:33], scale_log[40:39], invert[41], read_page[44:42],
    // read_column[51:45], zero[55:52]
    input  logic [55:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0]
    output logic [7:0]  m_axis_tdata
);

    localparam int DEPTH = SCREEN_COLUMNS * SCREEN_PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(SCREEN_COLUMNS);
    localparam int PW    = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
    localparam int XW    = scb_pkg::COORD_W;
    localparam logic signed [XW-1:0] COLS_S  = XW'(SCREEN_COLUMNS);
    localparam logic signed [XW-1:0] PAGES_S = XW'(SCREEN_PAGES);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_DRAW,
        ST_READ,
        ST_RDATA
    } state_t;

    // input fields
    logic [1:0]  mode;
    logic [7:0]  column_bits;
    logic [7:0]  origin_x;
    logic [6:0]  origin_y;
    logic [9:0]  offset_x;
    logic [5:0]  offset_page;
    logic [1:0]  scale_log;
    logic        invert;
    logic [2:0]  read_page;
    logic [6:0]  read_column;

    assign mode        = s_axis_tuser;
    assign column_bits = s_axis_tdata[7:0];
    assign origin_x    = s_axis_tdata[15:8];
    assign origin_y    = s_axis_tdata[22:16];
    assign offset_x    = s_axis_tdata[32:23];
    assign offset_page = s_axis_tdata[38:33];
    assign scale_log   = s_axis_tdata[40:39];
    assign invert      = s_axis_tdata[41];
    assign read_page   = s_axis_tdata[44:42];
    assign read_column = s_axis_tdata[51:45];

    state_t                 state_reg;
    logic [AW-1:0]          clr_cnt_reg;
    logic signed [XW-1:0]   bx_reg;       // leftmost destination column
    logic signed [XW-1:0]   by_reg;       // top destination row
    logic signed [XW-1:0]   pg_lo_reg;    // first page touched
    logic [3:0]             plast_reg;    // pages touched minus one
    logic [2:0]             sx_reg;       // column step inside the square
    logic [3:0]             pcnt_reg;     // page step
    logic [2:0]             rpage_reg;
    logic [6:0]             rcol_reg;
    scb_pkg::scb_draw_t     draw_reg;
    logic                   out_valid_reg;
    logic [7:0]             out_data_reg;

    scb_pkg::scb_req_t      req;
    logic [AW-1:0]          addr;
    logic [7:0]             rd_data;
    logic                   wb_busy;

    logic                   accept;
    logic                   out_take;
    logic signed [XW-1:0]   bx_in;
    logic signed [XW-1:0]   by_in;
    logic signed [XW-1:0]   pg_hi;
    logic signed [XW-1:0]   pg_lo;
    logic signed [XW-1:0]   plast_w;
    logic signed [XW-1:0]   col_w;
    logic signed [XW-1:0]   pg_w;
    logic                   draw_on_screen;
    logic                   read_in_range;
    logic [2:0]             sx_last;
    logic                   draw_done;
    logic [AW-1:0]          draw_addr;
    logic [AW-1:0]          read_addr;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_take = m_axis_tvalid && m_axis_tready;

    // draw origin at accept
    assign bx_in = $signed({{(XW-8){origin_x[7]}}, origin_x}) + $signed(XW'(offset_x));
    assign by_in = $signed({{(XW-7){origin_y[6]}}, origin_y})
                 + $signed(XW'({offset_page, 3'b000}));

    // page span of the scaled column, floor division for negative rows
    assign pg_lo   = by_reg >>> 3;
    assign pg_hi   = (by_reg + $signed((XW'(8) << draw_reg.scale_log) - XW'(1))) >>> 3;
    assign plast_w = pg_hi - pg_lo;

    // current column and page of the draw walk
    assign col_w = bx_reg + $signed(XW'(sx_reg));
    assign pg_w  = pg_lo_reg + $signed(XW'(pcnt_reg));
    assign draw_on_screen = !col_w[XW-1] && (col_w < COLS_S)
                         && !pg_w[XW-1] && (pg_w < PAGES_S);
    assign draw_addr = AW'(int'(pg_w[PW-1:0]) * SCREEN_COLUMNS + int'(col_w[CW-1:0]));

    assign sx_last   = 3'((4'd1 << draw_reg.scale_log) - 4'd1);
    assign draw_done = (pcnt_reg == plast_reg) && (sx_reg == sx_last);

    assign read_in_range = (int'(rpage_reg) < SCREEN_PAGES) && (int'(rcol_reg) < SCREEN_COLUMNS);
    assign read_addr     = AW'(int'(rpage_reg) * SCREEN_COLUMNS + int'(rcol_reg));

    // the last write back must land before a new item can touch the store
    assign s_axis_tready = (state_reg == ST_IDLE) && !wb_busy;

    // store request and address
    always_comb
    begin
        req.rd_en  = 1'b0;
        req.merge  = 1'b0;
        req.clr_en = 1'b0;
        req.row0   = (pg_w <<< 3) - by_reg;
        addr       = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                req.clr_en = 1'b1;
                addr       = clr_cnt_reg;
            end
            ST_DRAW:
            begin
                req.rd_en = draw_on_screen;
                req.merge = 1'b1;
                addr      = draw_addr;
            end
            ST_READ:
            begin
                req.rd_en = read_in_range && !out_valid_reg;
                addr      = read_addr;
            end
            ST_IDLE, ST_SETUP, ST_RDATA:
            begin
                addr = clr_cnt_reg;
            end
            default:
            begin
                addr = clr_cnt_reg;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            bx_reg        <= '0;
            by_reg        <= '0;
            pg_lo_reg     <= '0;
            plast_reg     <= '0;
            sx_reg        <= '0;
            pcnt_reg      <= '0;
            rpage_reg     <= '0;
            rcol_reg      <= '0;
            draw_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_take)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_cnt_reg == AW'(DEPTH - 1))
                    begin
                        clr_cnt_reg <= '0;
                        state_reg   <= ST_IDLE;
                    end
                    else
                        clr_cnt_reg <= clr_cnt_reg + AW'(1);
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (mode)
                            scb_pkg::MODE_DRAW:
                            begin
                                bx_reg             <= bx_in;
                                by_reg             <= by_in;
                                draw_reg.bits      <= column_bits ^ {8{invert}};
                                draw_reg.scale_log <= scale_log;
                                state_reg          <= ST_SETUP;
                            end
                            scb_pkg::MODE_CLEAR:
                            begin
                                clr_cnt_reg <= '0;
                                state_reg   <= ST_CLEAR;
                            end
                            scb_pkg::MODE_READ:
                            begin
                                rpage_reg <= read_page;
                                rcol_reg  <= read_column;
                                state_reg <= ST_READ;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SETUP:
                begin
                    pg_lo_reg <= pg_lo;
                    plast_reg <= plast_w[3:0];
                    sx_reg    <= '0;
                    pcnt_reg  <= '0;
                    state_reg <= ST_DRAW;
                end
                ST_DRAW:
                begin
                    if (draw_done)
                        state_reg <= ST_IDLE;
                    else if (pcnt_reg == plast_reg)
                    begin
                        pcnt_reg <= '0;
                        sx_reg   <= sx_reg + 3'd1;
                    end
                    else
                        pcnt_reg <= pcnt_reg + 4'd1;
                end
                ST_READ:
                begin
                    if (!out_valid_reg)
                    begin
                        if (read_in_range)
                            state_reg <= ST_RDATA;
                        else
                        begin
                            out_data_reg  <= 8'h00;
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                    end
                end
                ST_RDATA:
                begin
                    out_data_reg  <= rd_data;
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    scb_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .addr    (addr),
        .draw    (draw_reg),
        .rd_data (rd_data),
        .wb_busy (wb_busy)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_accept_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !wb_busy)
        else $error("item accepted with a write back pending");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_READ || $past(state_reg) == ST_RDATA))
        else $error("result produced outside a read");

    a_sx_in_square: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW) |-> (sx_reg <= sx_last) && (plast_reg <= 4'd8))
        else $error("draw walk left the scaled square");

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RDATA) |-> !out_valid_reg)
        else $error("read data would overwrite a waiting result");

endmodule

// File: sim/testbench.sv
// self-checking testbench for the scaled column blit frame store unit
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS     = 84;
    localparam int PAGES       = 6;
    localparam int HOLD_CYCLES = 300;  // long output stall in the pressure phase
    localparam int SETTLE      = 600;  // idle cycles at the end of the run

    // mode 3 is accepted and dropped by the block
    localparam logic [1:0] MODE_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [7:0]        column_bits;
        logic signed [7:0] origin_x;
        logic signed [6:0] origin_y;
        logic [9:0]        offset_x;
        logic [5:0]        offset_page;
        logic [1:0]        scale_log;
        logic              invert;
        logic [2:0]        read_page;
        logic [6:0]        read_column;
    } blit_item_t;

    // mirror of the frame store plus the read bytes still owed by the block
    class frame_mirror;
        logic [7:0] store [PAGES*COLUMNS];
        logic [7:0] reads_due [$];
        int errors;
        int reads_checked;
        int draws;
        int clears;
        int reads;
        int ignored;

        function new();
            wipe();
        endfunction

        function void wipe();
            foreach (store[i])
            begin
                store[i] = 8'h00;
            end
        endfunction

        // one pixel, silently clipped to the screen
        function void plot(int x, int y, bit on);
            int idx;
            if (x < 0 || x >= COLUMNS || y < 0 || y >= 8 * PAGES)
                return;
            idx = (y / 8) * COLUMNS + x;
            if (on)
                store[idx][y % 8] = 1'b1;
            else
                store[idx][y % 8] = 1'b0;
        endfunction

        // each source bit paints a size by size square, set or cleared
        function void blit_column(blit_item_t it);
            logic [7:0] bits;
            int size;
            int bx;
            int by;
            bits = it.invert ? ~it.column_bits : it.column_bits;
            size = 1 << it.scale_log;
            bx   = $signed(it.origin_x) + int'(it.offset_x);
            by   = $signed(it.origin_y) + 8 * int'(it.offset_page);
            for (int b = 0; b < 8; b++)
            begin
                for (int sy = 0; sy < size; sy++)
                begin
                    for (int sx = 0; sx < size; sx++)
                    begin
                        plot(bx + sx, by + b * size + sy, bits[b]);
                    end
                end
            end
        endfunction

        // called once per accepted input item
        function void note_item(blit_item_t it);
            unique case (it.mode)
                scb_pkg::MODE_DRAW:
                begin
                    draws++;
                    blit_column(it);
                end
                scb_pkg::MODE_CLEAR:
                begin
                    clears++;
                    wipe();
                end
                scb_pkg::MODE_READ:
                begin
                    reads++;
                    if (it.read_page < PAGES && it.read_column < COLUMNS)
                        reads_due.push_back(store[it.read_page * COLUMNS + it.read_column]);
                    else
                        reads_due.push_back(8'h00);
                end
                default:
                begin
                    ignored++;
                end
            endcase
        endfunction

        // called once per accepted output item
        function void check_read(logic [7:0] got);
            logic [7:0] want;
            if (reads_due.size() == 0)
            begin
                $error("read_data: expected nothing, actual %02h", got);
                errors++;
                return;
            end
            want = reads_due.pop_front();
            reads_checked++;
            if (got !== want)
            begin
                $error("read_data: expected %02h, actual %02h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = scb_pkg::MODE_DRAW;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    frame_mirror mirror = new();

    bit tx_gaps      = 1'b1;  // sender idles at random
    bit rx_gaps      = 1'b1;  // receiver idles at random
    bit hold_request = 1'b0;  // ask the receiver for one long stall
    int stall_left   = 0;

    scaled_column_blit_framebuffer_unit #(
        .SCREEN_COLUMNS(COLUMNS),
        .SCREEN_PAGES  (PAGES)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // all fields random; callers narrow them to useful ranges
    function automatic blit_item_t random_item();
        blit_item_t it;
        it.mode        = 2'($urandom);
        it.column_bits = 8'($urandom);
        it.origin_x    = 8'($urandom);
        it.origin_y    = 7'($urandom);
        it.offset_x    = 10'($urandom);
        it.offset_page = 6'($urandom);
        it.scale_log   = 2'($urandom);
        it.invert      = 1'($urandom);
        it.read_page   = 3'($urandom);
        it.read_column = 7'($urandom);
        return it;
    endfunction

    function automatic blit_item_t draw_item(logic [7:0] bits, int ox, int oy, int offx,
                                             int offp, int sl, bit inv);
        blit_item_t it;
        it             = random_item();
        it.mode        = scb_pkg::MODE_DRAW;
        it.column_bits = bits;
        it.origin_x    = 8'(ox);
        it.origin_y    = 7'(oy);
        it.offset_x    = 10'(offx);
        it.offset_page = 6'(offp);
        it.scale_log   = 2'(sl);
        it.invert      = inv;
        return it;
    endfunction

    function automatic blit_item_t read_item(int page, int col);
        blit_item_t it;
        it             = random_item();
        it.mode        = scb_pkg::MODE_READ;
        it.read_page   = 3'(page);
        it.read_column = 7'(col);
        return it;
    endfunction

    // mostly on-screen draws and in-range reads, with a tail of raw noise
    function automatic blit_item_t mixed_item();
        blit_item_t it;
        int pick;
        it   = random_item();
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            it.mode = scb_pkg::MODE_DRAW;
            if ($urandom_range(99) < 85)
            begin
                it.origin_x    = 8'(int'($urandom_range(100)) - 12);
                it.origin_y    = 7'(int'($urandom_range(56)) - 16);
                it.offset_x    = 10'($urandom_range(15));
                it.offset_page = 6'($urandom_range(3));
            end
        end
        else if (pick < 93)
        begin
            it.mode = scb_pkg::MODE_READ;
            if ($urandom_range(99) < 88)
            begin
                it.read_page   = 3'($urandom_range(PAGES - 1));
                it.read_column = 7'($urandom_range(COLUMNS - 1));
            end
        end
        else if (pick < 96)
        begin
            it.mode = scb_pkg::MODE_CLEAR;
        end
        else
        begin
            it.mode = MODE_NONE;
        end
        return it;
    endfunction

    // offer one item and hold it until the block takes it
    task automatic send_item(input blit_item_t it);
        while (tx_gaps && $urandom_range(99) < 20)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.mode;
        s_axis_tdata  <= {4'b0, it.read_column, it.read_page, it.invert, it.scale_log,
                          it.offset_page, it.offset_x, it.origin_y, it.origin_x,
                          it.column_bits};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        mirror.note_item(it);
    endtask

    task automatic send_mixed(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_item(mixed_item());
        end
    endtask

    // drop valid, then wait for every owed result
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (mirror.reads_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // output side: check each accepted item, then pick next cycle's ready
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            mirror.check_read(m_axis_tdata);
        if (hold_request)
        begin
            stall_left   = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= !(rx_gaps && $urandom_range(99) < 20);
        end
    end

    initial
    begin
        blit_item_t it;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed part: fresh store, each scale, clipping on every edge
        send_item(read_item(0, 0));
        send_item(draw_item(8'hA5, 0, 0, 0, 0, 0, 1'b0));
        send_item(read_item(0, 0));
        // scale 2 square straddles a page boundary
        send_item(draw_item(8'h3C, 10, 4, 0, 0, 1, 1'b0));
        send_item(read_item(0, 10));
        send_item(read_item(1, 11));
        // inverted zero column at scale 4 paints a solid bar
        send_item(draw_item(8'h00, 20, 8, 0, 0, 2, 1'b1));
        send_item(read_item(2, 22));
        // scale 8 running off the right and bottom edges
        send_item(draw_item(8'hFF, 80, 44, 0, 0, 3, 1'b0));
        send_item(read_item(5, 83));
        // negative origin, only part of the squares on screen
        send_item(draw_item(8'h81, -3, -5, 0, 0, 1, 1'b0));
        send_item(read_item(0, 0));
        // field extremes, entirely off screen
        send_item(draw_item(8'hFF, -128, -64, 1023, 63, 3, 1'b1));
        send_item(draw_item(8'h5A, 127, 63, 0, 0, 0, 1'b0));
        // offsets pull a far-negative origin back onto the screen
        send_item(draw_item(8'h0F, -60, -40, 60, 5, 2, 1'b0));
        send_item(read_item(0, 1));
        it      = random_item();
        it.mode = MODE_NONE;
        send_item(it);
        // reads outside the screen return zero
        send_item(read_item(7, 127));
        send_item(read_item(6, 0));
        send_item(read_item(0, 84));
        it      = random_item();
        it.mode = scb_pkg::MODE_CLEAR;
        send_item(it);
        send_item(read_item(2, 22));
        wait_drained();

        // random traffic with gaps on both sides
        send_mixed(300);
        wait_drained();

        // back to back on both sides
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        send_mixed(150);

        // output held off while reads keep coming, so the input must stall
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            send_item(read_item($urandom_range(PAGES - 1), $urandom_range(COLUMNS - 1)));
        end
        wait_drained();

        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        send_mixed(340);

        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d draws, %0d clears, %0d reads (%0d bytes checked), %0d ignored",
                 mirror.draws, mirror.clears, mirror.reads, mirror.reads_checked,
                 mirror.ignored);
        $display("clipped squares at every scale, out-of-range reads, %0d-cycle output stall",
                 HOLD_CYCLES);
        if (mirror.errors == 0 && mirror.reads_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
